@@ hdl/sas_pkg.sv @@
// ============================================================================
// sas_pkg
// Shared sizes, codes and helpers for the sparse array store.
// ============================================================================
package sas_pkg;

  // Array geometry: indices 0 .. 2^ROWS - 2 are in range.
  localparam int ROWS       = 10;
  localparam int DATA_WIDTH = 32;
  localparam int CAPACITY   = (1 << ROWS) - 1;

  // Valid bits are packed into rows of VWORD bits in a small memory.
  localparam int COL_W  = (ROWS >= 6) ? 5 : ROWS - 1;
  localparam int VROW_W = ROWS - COL_W;
  localparam int VWORD  = 1 << COL_W;
  localparam int VROWS  = 1 << VROW_W;

  // Fixed port widths.
  localparam int OP_W     = 2;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int HIGH_W   = 11;
  localparam int COUNT_W  = 10;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK       = 2'd0,
    RS_NOT_USED = 2'd1,
    RS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] pos;
  } hit_t;

  // Highest set bit of a valid-bit row.
  function automatic hit_t top_bit(input logic [VWORD-1:0] bits);
    hit_t h;
    h = '0;
    for (int i = 0; i < VWORD; i++) begin
      if (bits[i]) begin
        h.found = 1'b1;
        h.pos   = COL_W'(i);
      end
    end
    return h;
  endfunction

endpackage

@@ hdl/sparse_array_store_with_max_index.sv @@
// ============================================================================
// sparse_array_store_with_max_index
// Sparse array of signed words with a valid bit per index, an entry count
// and the highest used index.
// ============================================================================
// A request (set, get or delete on one index) is handled in two steps: the
// first accepts it and reads the entry and its valid-bit row, the second
// decides the result and writes back. A delete that removes the highest used
// index, when other entries remain and that index has no valid neighbour
// below it in its own row of 2^COL_W valid bits, then reads the rows below
// one at a time until one holds a valid bit (at most VROWS - 1 rows, 31 with
// the default geometry). The block takes one request at a time; the result
// sits in an output register, so the next request is accepted while it waits.
// Reset clears the valid-bit memory one row at a time before requests are taken.
// Values are held in a memory of 2^ROWS words that is never cleared: only
// entries marked valid are ever read back.
// ============================================================================
module sparse_array_store_with_max_index
  import sas_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_W-1:0]            in_operation,
  input  logic [INDEX_W-1:0]         in_index,
  input  logic signed [VALUE_W-1:0]  in_write_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_read_value,
  output logic signed [HIGH_W-1:0]   out_highest_index,
  output logic [COUNT_W-1:0]         out_entry_count
);

  // --------------------------------------------------------------------------
  // Memories: values (one word per index) and valid bits (rows of VWORD bits)
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] dmem [1 << ROWS];
  logic [VWORD-1:0]      vmem [VROWS];

  logic                  dwr_en;
  logic                  drd_en;
  logic [DATA_WIDTH-1:0] data_q_r;

  logic                  vwr_en;
  logic [VROW_W-1:0]     vwr_addr;
  logic [VWORD-1:0]      vwr_data;
  logic                  vrd_en;
  logic [VROW_W-1:0]     vrd_addr;
  logic [VWORD-1:0]      vrow_q_r;

  // --------------------------------------------------------------------------
  // Control and request registers
  // --------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [VROW_W-1:0]     clr_row_r;
  logic [OP_W-1:0]       op_r;
  logic                  rng_r;
  logic [ROWS-1:0]       idx_r;
  logic [DATA_WIDTH-1:0] wv_r;
  logic [ROWS-1:0]       count_r, count_nxt;
  logic [ROWS-1:0]       top_r, top_nxt;
  logic [VROW_W-1:0]     scan_row_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic [HIGH_W-1:0]     out_high_r;
  logic [COUNT_W-1:0]    out_count_r;

  // --------------------------------------------------------------------------
  // Lookup decision, taken in S_LOOKUP with the read data
  // --------------------------------------------------------------------------
  logic [VROW_W-1:0]  idx_row;
  logic [COL_W-1:0]   idx_col;
  logic [VWORD-1:0]   col_bit;
  logic [VWORD-1:0]   below;
  logic               cur_valid;
  hit_t               row_hit;
  hit_t               scan_hit;
  logic               out_free;

  status_t            lk_status;
  logic [VALUE_W-1:0] lk_value;
  logic [ROWS-1:0]    lk_count;
  logic [ROWS-1:0]    lk_top;
  logic               lk_vwr;
  logic [VWORD-1:0]   lk_vrow;
  logic               lk_dwr;
  logic               lk_scan;

  assign idx_row   = idx_r[ROWS-1:COL_W];
  assign idx_col   = idx_r[COL_W-1:0];
  assign col_bit   = VWORD'(1) << idx_col;
  assign below     = vrow_q_r & (col_bit - VWORD'(1));
  assign cur_valid = vrow_q_r[idx_col];
  assign row_hit   = top_bit(below);
  assign scan_hit  = top_bit(vrow_q_r);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    lk_status = RS_OK;
    lk_value  = '0;
    lk_count  = count_r;
    lk_top    = top_r;
    lk_vwr    = 1'b0;
    lk_vrow   = vrow_q_r;
    lk_dwr    = 1'b0;
    lk_scan   = 1'b0;
    if (op_r == 2'(OP_SET) || op_r == 2'(OP_GET) || op_r == 2'(OP_DELETE)) begin
      if (rng_r) begin
        lk_status = RS_RANGE;
      end else begin
        case (op_t'(op_r))
          OP_SET: begin
            lk_vwr  = 1'b1;
            lk_vrow = vrow_q_r | col_bit;
            lk_dwr  = 1'b1;
            if (!cur_valid) begin
              lk_count = count_r + ROWS'(1);
            end
            if (count_r == '0 || idx_r > top_r) begin
              lk_top = idx_r;
            end
          end
          OP_GET: begin
            if (!cur_valid) begin
              lk_status = RS_NOT_USED;
            end else begin
              lk_value = VALUE_W'(signed'(data_q_r));
            end
          end
          default: begin
            // delete
            if (!cur_valid) begin
              lk_status = RS_NOT_USED;
            end else begin
              lk_vwr   = 1'b1;
              lk_vrow  = vrow_q_r & ~col_bit;
              lk_count = count_r - ROWS'(1);
              if (count_r != ROWS'(1) && idx_r == top_r) begin
                if (row_hit.found) begin
                  lk_top = {idx_row, row_hit.pos};
                end else begin
                  lk_scan = 1'b1;
                end
              end
            end
          end
        endcase
      end
    end else begin
      lk_status = RS_NOT_USED;
    end
  end

  // --------------------------------------------------------------------------
  // State machine: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_row_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          state_nxt = lk_scan ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_hit.found && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // State machine: memory strobes and handshake
  // --------------------------------------------------------------------------
  logic emit;

  always_comb begin
    in_stall = 1'b1;
    drd_en   = 1'b0;
    dwr_en   = 1'b0;
    vrd_en   = 1'b0;
    vrd_addr = in_index[ROWS-1:COL_W];
    vwr_en   = 1'b0;
    vwr_addr = idx_row;
    vwr_data = lk_vrow;
    emit     = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        // wipe one valid-bit row a cycle
        vwr_en   = 1'b1;
        vwr_addr = clr_row_r;
        vwr_data = '0;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        drd_en   = in_valid;
        vrd_en   = in_valid;
      end
      S_LOOKUP: begin
        if (out_free) begin
          vwr_en   = lk_vwr;
          dwr_en   = lk_dwr;
          vrd_en   = lk_scan;
          vrd_addr = idx_row - VROW_W'(1);
          emit     = !lk_scan;
        end
      end
      S_SCAN: begin
        vrd_addr = scan_row_r - VROW_W'(1);
        if (!scan_hit.found) begin
          vrd_en = 1'b1;
        end else begin
          emit = out_free;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Next count and top
  // --------------------------------------------------------------------------
  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (state_r == S_LOOKUP && out_free) begin
      count_nxt = lk_count;
      top_nxt   = lk_top;
    end else if (state_r == S_SCAN && scan_hit.found && out_free) begin
      top_nxt = {scan_row_r, scan_hit.pos};
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (dwr_en) begin
      dmem[idx_r] <= wv_r;
    end
    if (drd_en) begin
      data_q_r <= dmem[in_index[ROWS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vmem[vwr_addr] <= vwr_data;
    end
    if (vrd_en) begin
      vrow_q_r <= vmem[vrd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      top_r   <= top_nxt;
      if (state_r == S_CLEAR) begin
        clr_row_r <= clr_row_r + VROW_W'(1);
      end
      // hold the result until taken, then drop or replace it
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request and result payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r  <= in_operation;
      rng_r <= {1'b0, in_index} >= (INDEX_W + 1)'(CAPACITY);
      idx_r <= in_index[ROWS-1:0];
      wv_r  <= DATA_WIDTH'(in_write_value);
    end
    if (state_r == S_LOOKUP && out_free) begin
      scan_row_r <= idx_row - VROW_W'(1);
    end else if (state_r == S_SCAN && !scan_hit.found) begin
      scan_row_r <= scan_row_r - VROW_W'(1);
    end
    if (emit) begin
      out_status_r <= (state_r == S_SCAN) ? STATUS_W'(RS_OK) : STATUS_W'(lk_status);
      out_value_r  <= (state_r == S_SCAN) ? '0 : lk_value;
      out_high_r   <= (count_nxt == '0) ? '1 : HIGH_W'(top_nxt);
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_value_r;
  assign out_highest_index = out_high_r;
  assign out_entry_count   = out_count_r;

endmodule

@@ sim/tb_sparse_array_store_with_max_index.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_array_store_with_max_index
// Self-checking bench for the sparse array store: directed corner cases, then
// random set/get/delete traffic under varied idling and one long result hold-off.
// A shadow copy of the array predicts every result, which is compared field by
// field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_sparse_array_store_with_max_index;
  import sas_pkg::*;

  // Code with no operation behind it; the block must answer "entry not in use".
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 64;     // longest downward search plus margin
  localparam int HOLD_CYCLES  = 300;    // long result hold-off
  localparam int MAX_REPORTS  = 50;
  localparam int RANDOM_ITEMS = 290;    // per random phase

  typedef struct {
    status_t                    status;
    logic signed [VALUE_W-1:0]  value;
    logic signed [HIGH_W-1:0]   top;
    logic [COUNT_W-1:0]         count;
  } store_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OP_W-1:0]            in_operation = '0;
  logic [INDEX_W-1:0]         in_index = '0;
  logic signed [VALUE_W-1:0]  in_write_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic signed [VALUE_W-1:0]  out_read_value;
  logic signed [HIGH_W-1:0]   out_highest_index;
  logic [COUNT_W-1:0]         out_entry_count;

  // Shadow copy of the array, updated as each request is accepted.
  logic signed [VALUE_W-1:0]  shadow_value [CAPACITY];
  bit                         shadow_used  [CAPACITY];
  int                         shadow_count = 0;
  int                         shadow_top   = -1;

  store_result_t              pending_results [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_trigger  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int win_base      = 0;

  int cycle_count     = 0;
  int mismatches      = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int n_ok            = 0;
  int n_not_used      = 0;
  int n_range         = 0;
  int top_searches    = 0;
  int peak_top        = -1;

  sparse_array_store_with_max_index dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_index          (in_index),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_highest_index (out_highest_index),
    .out_entry_count   (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abandon the run if it hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL sparse_array_store_with_max_index");
      $finish;
    end
  end

  // Count out the long hold-off; a new one starts whenever the trigger moves on.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: stall at random, and solidly during a hold-off.
  always @(posedge clk) begin
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // Work out the result of one request and advance the shadow copy.
  function automatic store_result_t predict_store_response(
      input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
      input logic signed [VALUE_W-1:0] wv);
    store_result_t r;
    int k;
    r.value = '0;
    if (op == OP_UNUSED) begin
      r.status = RS_NOT_USED;
    end else if (idx >= CAPACITY) begin
      r.status = RS_RANGE;
    end else if (op == OP_SET) begin
      if (!shadow_used[idx]) begin
        shadow_used[idx] = 1'b1;
        shadow_count++;
      end
      if (int'(idx) > shadow_top) shadow_top = int'(idx);
      shadow_value[idx] = wv;
      r.status = RS_OK;
    end else if (!shadow_used[idx]) begin
      r.status = RS_NOT_USED;
    end else if (op == OP_GET) begin
      r.status = RS_OK;
      r.value  = shadow_value[idx];
    end else begin
      shadow_used[idx] = 1'b0;
      shadow_count--;
      if (shadow_count == 0) begin
        shadow_top = -1;
      end else if (int'(idx) == shadow_top) begin
        k = int'(idx) - 1;
        while (k >= 0 && !shadow_used[k]) k--;
        shadow_top = k;
        top_searches++;
      end
      r.status = RS_OK;
    end
    if (shadow_top > peak_top) peak_top = shadow_top;
    r.top   = HIGH_W'(shadow_top);
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_REPORTS)
      $display("Mismatch at cycle %0d, result %0d: %s got %0d, expected %0d",
               cycle_count, results_checked, what, got, want);
    mismatches++;
  endtask

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    store_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_read_value !== want.value)
          report_mismatch("read value", out_read_value, want.value);
        if (out_highest_index !== want.top)
          report_mismatch("highest index", out_highest_index, want.top);
        if (out_entry_count !== want.count)
          report_mismatch("entry count", out_entry_count, want.count);
        case (want.status)
          RS_OK:       n_ok++;
          RS_NOT_USED: n_not_used++;
          default:     n_range++;
        endcase
        results_checked++;
      end
    end
  end

  // Offer one request, with a random gap first, and hold it until accepted.
  // Entered and left in the time step of a rising edge.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic signed [VALUE_W-1:0] wv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_index       <= idx;
    in_write_value <= wv;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(predict_store_response(op, idx, wv));
    requests_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly a small window so that entries get reused, some spread, some out of range.
  function automatic logic [INDEX_W-1:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 60) return INDEX_W'(win_base + $urandom_range(63));
    if (r < 85) return INDEX_W'($urandom_range(CAPACITY - 1));
    if (r < 90) return INDEX_W'($urandom_range(CAPACITY - 2, CAPACITY));
    return INDEX_W'($urandom_range(CAPACITY, 65535));
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return {1'b1, {(VALUE_W-1){1'b0}}};
    if (r < 16) return {1'b0, {(VALUE_W-1){1'b1}}};
    if (r < 20) return '0;
    if (r < 24) return '1;
    return VALUE_W'($urandom);
  endfunction

  task automatic run_random_requests(input int count);
    int r;
    int lo;
    int hi;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    win_base = $urandom_range(CAPACITY - 64);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // Plant a low and a high entry, then delete the high one so that, when it is
        // the top, the top has to be searched for downwards.
        lo = $urandom_range(CAPACITY - 40);
        hi = $urandom_range(lo + 1, CAPACITY - 1);
        send_request(OP_SET, INDEX_W'(lo), pick_value());
        send_request(OP_SET, INDEX_W'(hi), pick_value());
        send_request(OP_DELETE, INDEX_W'(hi), pick_value());
        n += 2;
      end else begin
        r = $urandom_range(99);
        if (r < 40)      op = OP_SET;
        else if (r < 68) op = OP_GET;
        else if (r < 96) op = OP_DELETE;
        else             op = OP_UNUSED;
        idx = pick_index();
        // Aim some deletes at the current top entry.
        if (op == OP_DELETE && shadow_top >= 0 && $urandom_range(99) < 30)
          idx = INDEX_W'(shadow_top);
        send_request(op, idx, pick_value());
      end
    end
    wait_until_drained();
  endtask

  // Corner cases, back to back.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct    <= 0;
    send_request(OP_GET,    16'd0,     32'sd0);          // empty array
    send_request(OP_DELETE, 16'd5,     32'sd0);          // delete of an unused entry
    send_request(OP_SET,    16'd0,     32'h7FFF_FFFF);   // lowest index, largest value
    send_request(OP_SET,    16'd1022,  32'h8000_0000);   // highest index, smallest value
    send_request(OP_GET,    16'd0,     32'sd0);
    send_request(OP_GET,    16'd1022,  32'sd0);
    send_request(OP_SET,    16'd1022,  -32'sd1);         // overwrite keeps the count
    send_request(OP_GET,    16'd1022,  32'sd0);
    send_request(OP_SET,    16'd1023,  32'sd7);          // first index out of range
    send_request(OP_GET,    16'd1023,  32'sd0);
    send_request(OP_DELETE, 16'hFFFF,  32'sd0);
    send_request(OP_SET,    16'hFFFF,  -32'sd1);
    send_request(OP_UNUSED, 16'd0,     32'sd0);          // unused operation code
    send_request(OP_SET,    16'd31,    32'sd0);          // either side of a valid-bit row
    send_request(OP_SET,    16'd32,    32'sd12345);
    send_request(OP_DELETE, 16'd1022,  32'sd0);          // top falls through many rows
    send_request(OP_DELETE, 16'd32,    32'sd0);          // top crosses a row boundary
    send_request(OP_DELETE, 16'd0,     32'sd0);          // not the top
    send_request(OP_GET,    16'd0,     32'sd0);
    send_request(OP_DELETE, 16'd31,    32'sd0);          // last entry: empty again
    send_request(OP_SET,    16'd5,     -32'sd1);
    send_request(OP_SET,    16'd700,   32'sd99);
    send_request(OP_DELETE, 16'd700,   32'sd0);          // long search down to a lone entry
    send_request(OP_GET,    16'd5,     32'sd0);
    send_request(OP_UNUSED, 16'hFFFF,  -32'sd1);
    wait_until_drained();
  endtask

  task automatic test_random_free_flowing();
    send_idle_pct = 0;
    stall_pct    <= 0;
    run_random_requests(RANDOM_ITEMS);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct = 84;
    stall_pct    <= 0;
    run_random_requests(RANDOM_ITEMS);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct = 0;
    stall_pct    <= 84;
    run_random_requests(RANDOM_ITEMS);
  endtask

  task automatic test_random_both_idling();
    send_idle_pct = 14;
    stall_pct    <= 14;
    run_random_requests(RANDOM_ITEMS);
  endtask

  // Hold off the results for a long stretch while requests keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_trigger <= hold_trigger + 1;
    run_random_requests(40);
  endtask

  initial begin
    // Hold reset, then release; the block clears its valid bits on its own and
    // stalls requests meanwhile, which the handshake absorbs.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_free_flowing();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idling();
    test_backpressure_fill();

    // Let any stray result show itself before judging.
    stall_pct <= 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d requests: %0d ok, %0d entry not in use, %0d out of range",
             results_checked, requests_sent, n_ok, n_not_used, n_range);
    $display("Deletes of the top entry that searched downwards: %0d; highest index used: %0d",
             top_searches, peak_top);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS sparse_array_store_with_max_index");
    end else begin
      $display("FAIL sparse_array_store_with_max_index");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sas_pkg.sv
hdl/sparse_array_store_with_max_index.sv
sim/tb_sparse_array_store_with_max_index.sv
